### design/tli_pkg.sv
// Shared opcodes, result codes and fixed field widths of the table interpolator.
package tli_pkg;

  localparam int CFG_W  = 7;
  localparam int IDX_W  = 6;
  localparam int OUTC_W = 3;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [OUTC_W-1:0] {
    OUTC_INTERP   = 3'd0,
    OUTC_EXACT    = 3'd1,
    OUTC_CLAMP_LO = 3'd2,
    OUTC_CLAMP_HI = 3'd3,
    OUTC_EMPTY    = 3'd4
  } outcome_t;

endpackage

### design/tli_mem.sv
// Point table memory: one write port, one registered read port.
module tli_mem #(
  parameter int DEPTH = 64,
  parameter int W     = 80
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [W-1:0]             wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [W-1:0]             rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/tli_muldiv.sv
// Iterative floor(dx * dy / den) for dx < den, one bit of dy per cycle.
module tli_muldiv #(
  parameter int W = 40
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dx,
  input  logic [W-1:0] dy,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo
);

  localparam int CW = $clog2(W);

  logic [W-1:0]  dx_r, dy_r, den_r, rem_r, quo_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;

  logic [W+1:0]  t, den1, den2;
  logic [W-1:0]  rem_nxt, quo_nxt;
  logic [1:0]    dig;

  // Partial product stays below 3*den, so each step yields a digit of 0..2.
  always_comb begin
    den1 = {2'b00, den_r};
    den2 = {1'b0, den_r, 1'b0};
    t    = {1'b0, rem_r, 1'b0} + (dy_r[W-1] ? {2'b00, dx_r} : '0);
    if (t >= den2) begin
      rem_nxt = W'(t - den2);
      dig     = 2'd2;
    end else if (t >= den1) begin
      rem_nxt = W'(t - den1);
      dig     = 2'd1;
    end else begin
      rem_nxt = W'(t);
      dig     = 2'd0;
    end
    quo_nxt = {quo_r[W-2:0], 1'b0} + W'(dig);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W - 1);
        rem_r  <= '0;
        quo_r  <= '0;
        dx_r   <= dx;
        dy_r   <= dy;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        dy_r  <= {dy_r[W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### design/table_linear_interpolator.sv
// Table linear interpolator: unsorted (x, y) point table with interpolating query.
//
// An item is taken at a clock edge with start high and busy low. A write item
// (opcode write) stores one point and keeps busy low; a write to a slot at or
// beyond TABLE_DEPTH is dropped. A query item on a table of N entries (N = cfg
// register, capped at TABLE_DEPTH) keeps busy low if N is 0; else it raises
// busy, scans entries 0 .. N-1 one per cycle out of the point memory, then,
// when no exact match or clamp applies, runs the multiply-divide unit, one bit
// of the ordinate difference per cycle. A query ends on an exact match, a
// clamp, an interpolation, or for an empty table the empty outcome.
// The result is shown for one cycle with out_strobe high; the receiver cannot
// stall it. busy drops in the cycle of the strobe, so the next item may follow.
// Reset clears the control state and the entry count; the table contents stay
// undefined until written. cfg_data is written at an edge with cfg_we high,
// by the user only while the block is idle; the block itself does not enforce it.
module table_linear_interpolator #(
  parameter int TABLE_DEPTH = 64,
  parameter int VALUE_BITS  = 40
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_opcode,
  input  logic [tli_pkg::IDX_W-1:0]           in_entry_index,
  input  logic signed [VALUE_BITS-1:0]        in_entry_x,
  input  logic signed [VALUE_BITS-1:0]        in_entry_y,
  input  logic signed [VALUE_BITS-1:0]        in_query_x,
  output logic                                out_strobe,
  output logic signed [VALUE_BITS-1:0]        out_value_y,
  output logic [tli_pkg::OUTC_W-1:0]          out_outcome,
  input  logic                                cfg_we,
  input  logic [tli_pkg::CFG_W-1:0]           cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int V  = VALUE_BITS;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DIV} state_t;

  state_t                      state_r;
  logic [tli_pkg::CFG_W-1:0]   cfg_r;
  logic [CW-1:0]               count_sat, count_r, addr_r;
  logic                        data_vld_r, md_start_r;
  logic signed [V-1:0]         q_r, lo_x_r, lo_y_r, hi_x_r, hi_y_r, match_y_r;
  logic                        have_lo_r, have_hi_r, match_r;
  logic                        out_strobe_r;
  logic signed [V-1:0]         out_value_r;
  tli_pkg::outcome_t           out_outcome_r;

  logic                        accept, wr_en, rd_en;
  logic [AW-1:0]               wr_addr, rd_addr;
  logic [2*V-1:0]              rd_data;
  logic signed [V-1:0]         xj, yj;
  logic [V-1:0]                md_dx, md_dy, md_den, md_quo;
  logic                        md_neg, md_done;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign count_sat = ({25'd0, cfg_r} > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cfg_r);

  assign wr_en   = accept && (in_opcode == tli_pkg::OP_WRITE) &&
                   (32'(in_entry_index) < 32'(TABLE_DEPTH));
  assign wr_addr = AW'(in_entry_index);
  assign rd_en   = (state_r == S_SCAN) && (addr_r != count_r);
  assign rd_addr = addr_r[AW-1:0];

  tli_mem #(
    .DEPTH (TABLE_DEPTH),
    .W     (2 * V)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({in_entry_x, in_entry_y}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign xj = $signed(rd_data[2*V-1:V]);
  assign yj = $signed(rd_data[V-1:0]);

  // Operands for the bracket found by the scan; dx < den by construction.
  assign md_neg = (hi_y_r < lo_y_r);
  assign md_dx  = V'(q_r - lo_x_r);
  assign md_den = V'(hi_x_r - lo_x_r);
  assign md_dy  = md_neg ? V'(lo_y_r - hi_y_r) : V'(hi_y_r - lo_y_r);

  tli_muldiv #(
    .W (V)
  ) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start_r),
    .dx    (md_dx),
    .dy    (md_dy),
    .den   (md_den),
    .done  (md_done),
    .quo   (md_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_r        <= '0;
      data_vld_r   <= 1'b0;
      md_start_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      md_start_r   <= 1'b0;
      data_vld_r   <= rd_en;
      if (cfg_we) begin
        cfg_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_opcode == tli_pkg::OP_QUERY)) begin
            q_r       <= in_query_x;
            count_r   <= count_sat;
            addr_r    <= '0;
            have_lo_r <= 1'b0;
            have_hi_r <= 1'b0;
            match_r   <= 1'b0;
            if (count_sat == '0) begin
              out_strobe_r  <= 1'b1;
              out_value_r   <= '0;
              out_outcome_r <= tli_pkg::OUTC_EMPTY;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            addr_r <= addr_r + 1'b1;
          end
          if (data_vld_r) begin
            if (xj == q_r) begin
              if (!match_r) begin
                match_r   <= 1'b1;
                match_y_r <= yj;
              end
            end else if (q_r < xj) begin
              if (!have_hi_r || xj < hi_x_r) begin
                have_hi_r <= 1'b1;
                hi_x_r    <= xj;
                hi_y_r    <= yj;
              end
            end else if (!have_lo_r || xj > lo_x_r) begin
              have_lo_r <= 1'b1;
              lo_x_r    <= xj;
              lo_y_r    <= yj;
            end
          end else if (addr_r == count_r) begin
            // all entries seen: pick the kind of answer
            if (match_r) begin
              state_r       <= S_IDLE;
              out_strobe_r  <= 1'b1;
              out_value_r   <= match_y_r;
              out_outcome_r <= tli_pkg::OUTC_EXACT;
            end else if (!have_lo_r) begin
              state_r       <= S_IDLE;
              out_strobe_r  <= 1'b1;
              out_value_r   <= hi_y_r;
              out_outcome_r <= tli_pkg::OUTC_CLAMP_LO;
            end else if (!have_hi_r) begin
              state_r       <= S_IDLE;
              out_strobe_r  <= 1'b1;
              out_value_r   <= lo_y_r;
              out_outcome_r <= tli_pkg::OUTC_CLAMP_HI;
            end else begin
              state_r    <= S_DIV;
              md_start_r <= 1'b1;
            end
          end
        end
        S_DIV: begin
          if (md_done) begin
            state_r       <= S_IDLE;
            out_strobe_r  <= 1'b1;
            out_value_r   <= md_neg ? (lo_y_r - $signed(md_quo)) : (lo_y_r + $signed(md_quo));
            out_outcome_r <= tli_pkg::OUTC_INTERP;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe  = out_strobe_r;
  assign out_value_y = out_value_r;
  assign out_outcome = out_outcome_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while a query is still in progress");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide phase");

  a_empty_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_opcode == tli_pkg::OP_QUERY) && (count_sat == '0))
      |=> (out_strobe && (out_outcome == tli_pkg::OUTC_EMPTY) && !busy))
    else $error("empty-table query did not answer in one cycle");

  a_no_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !data_vld_r)
    else $error("table write overlaps a scan read");

endmodule

### dv/table_linear_interpolator_checker.sv
// Checker for the table interpolator: mirrors the point table, predicts each query, compares.
`timescale 1ns / 1ps
module table_linear_interpolator_checker #(
  parameter int TABLE_DEPTH = 64,
  parameter int VALUE_BITS  = 40
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           in_opcode,
  input  logic [tli_pkg::IDX_W-1:0]      in_entry_index,
  input  logic signed [VALUE_BITS-1:0]   in_entry_x,
  input  logic signed [VALUE_BITS-1:0]   in_entry_y,
  input  logic signed [VALUE_BITS-1:0]   in_query_x,
  input  logic                           out_strobe,
  input  logic signed [VALUE_BITS-1:0]   out_value_y,
  input  logic [tli_pkg::OUTC_W-1:0]     out_outcome,
  input  logic                           cfg_we,
  input  logic [tli_pkg::CFG_W-1:0]      cfg_data,
  output int                             mismatches,
  output int                             awaited
);

  typedef logic signed [VALUE_BITS-1:0] fix_t;

  typedef struct {
    fix_t              value_y;
    tli_pkg::outcome_t outcome;
  } answer_t;

  fix_t    point_x [TABLE_DEPTH];
  fix_t    point_y [TABLE_DEPTH];
  int      span;
  answer_t answers[$];

  function automatic answer_t evaluate(input fix_t q);
    answer_t    a;
    int         n;
    int         j;
    int         lo;
    int         hi;
    bit         have_lo;
    bit         have_hi;
    longint     dx;
    longint     den;
    longint     dy;
    longint     mag;
    logic [127:0] quo;
    a.value_y = '0;
    a.outcome = tli_pkg::OUTC_EMPTY;
    n = (span > TABLE_DEPTH) ? TABLE_DEPTH : span;
    if (n == 0) return a;
    lo = 0;
    hi = 0;
    have_lo = 1'b0;
    have_hi = 1'b0;
    for (j = 0; j < n; j++) begin
      if (point_x[j] == q) begin
        a.value_y = point_y[j];
        a.outcome = tli_pkg::OUTC_EXACT;
        return a;
      end
      // strict compares keep the first entry found on ties
      if (q < point_x[j]) begin
        if (!have_hi || point_x[j] < point_x[hi]) begin
          hi = j;
          have_hi = 1'b1;
        end
      end else if (!have_lo || point_x[j] > point_x[lo]) begin
        lo = j;
        have_lo = 1'b1;
      end
    end
    if (!have_lo) begin
      a.value_y = point_y[hi];
      a.outcome = tli_pkg::OUTC_CLAMP_LO;
      return a;
    end
    if (!have_hi) begin
      a.value_y = point_y[lo];
      a.outcome = tli_pkg::OUTC_CLAMP_HI;
      return a;
    end
    dx  = longint'(q) - longint'(point_x[lo]);
    den = longint'(point_x[hi]) - longint'(point_x[lo]);
    dy  = longint'(point_y[hi]) - longint'(point_y[lo]);
    mag = (dy < 0) ? -dy : dy;
    // magnitude divided, sign applied after: truncation toward zero
    quo = (128'(dx) * 128'(mag)) / 128'(den);
    if (dy < 0)
      a.value_y = fix_t'(longint'(point_y[lo]) - longint'(quo[63:0]));
    else
      a.value_y = fix_t'(longint'(point_y[lo]) + longint'(quo[63:0]));
    a.outcome = tli_pkg::OUTC_INTERP;
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst_n) begin
      answers.delete();
      span = 0;
      mismatches = 0;
    end else begin
      if (out_strobe) begin
        if (answers.size() == 0) begin
          $error("result with no query pending: value_y %0d outcome %0d",
                 out_value_y, out_outcome);
          mismatches++;
        end else begin
          exp_a = answers.pop_front();
          if (out_value_y !== exp_a.value_y) begin
            $error("value_y: expected %0d, got %0d", exp_a.value_y, out_value_y);
            mismatches++;
          end
          if (out_outcome !== exp_a.outcome) begin
            $error("outcome: expected %0d, got %0d", exp_a.outcome, out_outcome);
            mismatches++;
          end
        end
      end
      if (cfg_we) span = int'(cfg_data);
      if (start && !busy) begin
        if (in_opcode == tli_pkg::OP_WRITE) begin
          if (int'(in_entry_index) < TABLE_DEPTH) begin
            point_x[in_entry_index] = in_entry_x;
            point_y[in_entry_index] = in_entry_y;
          end
        end else begin
          answers.push_back(evaluate(in_query_x));
        end
      end
    end
    awaited = answers.size();
  end

endmodule

### dv/table_linear_interpolator_tb.sv
// Testbench top for the table interpolator: clock, reset, item and register stimulus, verdict.
`timescale 1ns / 1ps
module table_linear_interpolator_tb;

  localparam int TABLE_DEPTH = 64;
  localparam int VALUE_BITS  = 40;

  typedef logic signed [VALUE_BITS-1:0] fix_t;

  localparam fix_t VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam fix_t VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam longint ONE = 65536;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic                          in_opcode;
  logic [tli_pkg::IDX_W-1:0]     in_entry_index;
  fix_t                          in_entry_x;
  fix_t                          in_entry_y;
  fix_t                          in_query_x;
  logic                          out_strobe;
  fix_t                          out_value_y;
  logic [tli_pkg::OUTC_W-1:0]    out_outcome;
  logic                          cfg_we;
  logic [tli_pkg::CFG_W-1:0]     cfg_data;

  int   mismatches;
  int   awaited;
  int   items_issued;
  int   span;
  bit   no_idle;
  fix_t shadow_x [TABLE_DEPTH];

  table_linear_interpolator #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_entry_index (in_entry_index),
    .in_entry_x     (in_entry_x),
    .in_entry_y     (in_entry_y),
    .in_query_x     (in_query_x),
    .out_strobe     (out_strobe),
    .out_value_y    (out_value_y),
    .out_outcome    (out_outcome),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data)
  );

  table_linear_interpolator_checker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_entry_index (in_entry_index),
    .in_entry_x     (in_entry_x),
    .in_entry_y     (in_entry_y),
    .in_query_x     (in_query_x),
    .out_strobe     (out_strobe),
    .out_value_y    (out_value_y),
    .out_outcome    (out_outcome),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .awaited        (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic fix_t rand_val();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return fix_t'(r[VALUE_BITS-1:0]);
  endfunction

  // grid values make exact hits and duplicate abscissas common
  function automatic fix_t pick_x();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return fix_t'((longint'($urandom_range(0, 40)) - 20) * ONE);
      4:          return ($urandom_range(0, 1) != 0) ? VAL_MAX : VAL_MIN;
      5:          return fix_t'(longint'($urandom_range(0, 2000)) - 1000);
      default:    return rand_val();
    endcase
  endfunction

  function automatic fix_t pick_query();
    int n;
    n = (span > TABLE_DEPTH) ? TABLE_DEPTH : span;
    case ($urandom_range(0, 9))
      0, 1, 2: return shadow_x[$urandom_range(0, (n > 0) ? n - 1 : TABLE_DEPTH - 1)];
      3, 4, 5: return fix_t'((longint'($urandom_range(0, 50)) - 25) * ONE
                             + longint'($urandom_range(0, 65535)));
      6: begin
        case ($urandom_range(0, 3))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return VAL_MIN + 1;
          default: return VAL_MAX - 1;
        endcase
      end
      default: return rand_val();
    endcase
  endfunction

  // called just after the rising clock; returns once the item is taken and the gap is over
  task automatic push_item(input tli_pkg::opcode_t op, input logic [tli_pkg::IDX_W-1:0] idx,
                           input fix_t ex, input fix_t ey, input fix_t qx);
    int gap;
    start          <= 1'b1;
    in_opcode      <= op;
    in_entry_index <= idx;
    in_entry_x     <= ex;
    in_entry_y     <= ey;
    in_query_x     <= qx;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    items_issued++;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_point(input int idx, input fix_t x, input fix_t y);
    shadow_x[idx] = x;
    push_item(tli_pkg::OP_WRITE, tli_pkg::IDX_W'(idx), x, y, rand_val());
  endtask

  task automatic ask(input fix_t q);
    push_item(tli_pkg::OP_QUERY, tli_pkg::IDX_W'($urandom_range(0, TABLE_DEPTH - 1)),
              rand_val(), rand_val(), q);
  endtask

  // hold the sender off until every query has answered and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (awaited != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_span(input int v);
    drain();
    span = v;
    cfg_we   <= 1'b1;
    cfg_data <= tli_pkg::CFG_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int idx;
    int order[TABLE_DEPTH];
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_opcode      <= tli_pkg::OP_WRITE;
    in_entry_index <= '0;
    in_entry_x     <= '0;
    in_entry_y     <= '0;
    in_query_x     <= '0;
    cfg_we         <= 1'b0;
    cfg_data       <= '0;
    items_issued = 0;
    span = 0;
    no_idle = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table after reset
    ask(VAL_MAX);
    ask(VAL_MIN);

    // full-range points, slot 3 repeats the lowest abscissa
    write_point(0, VAL_MIN, VAL_MAX);
    write_point(1, VAL_MAX, VAL_MIN);
    write_point(2, '0, fix_t'(291 * ONE));
    write_point(3, VAL_MIN, '0);
    set_span(4);
    ask(VAL_MIN);
    ask(VAL_MAX);
    ask('0);
    ask(fix_t'(-1));
    ask(fix_t'(1));

    // widest span between neighbors
    set_span(2);
    ask('0);
    ask(VAL_MIN + 1);
    ask(VAL_MAX - 1);

    // clamps at both ends, tie on the low end
    write_point(0, fix_t'(-5 * ONE), fix_t'(3 * ONE));
    write_point(1, fix_t'(5 * ONE), fix_t'(-9 * ONE));
    write_point(2, fix_t'(-5 * ONE), fix_t'(77));
    set_span(3);
    ask(fix_t'(-6 * ONE));
    ask(fix_t'(7 * ONE));
    ask(fix_t'(32768));

    // fill every slot in shuffled order so any span is legal afterwards
    for (idx = 0; idx < TABLE_DEPTH; idx++) order[idx] = idx;
    order.shuffle();
    for (idx = 0; idx < TABLE_DEPTH; idx++) write_point(order[idx], pick_x(), rand_val());

    while (items_issued < 950) begin
      case ($urandom_range(0, 7))
        0:       set_span(0);
        1:       set_span(1);
        2:       set_span(2);
        3:       set_span(TABLE_DEPTH);
        4:       set_span($urandom_range(TABLE_DEPTH + 1, 127));
        default: set_span($urandom_range(1, TABLE_DEPTH));
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(20, 50)) begin
        if ($urandom_range(0, 9) < 3)
          write_point($urandom_range(0, TABLE_DEPTH - 1), pick_x(), rand_val());
        else
          ask(pick_query());
      end
    end

    drain();
    repeat (120) @(posedge clk);
    if (mismatches == 0 && awaited == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

### table_linear_interpolator.f
design/tli_pkg.sv
design/tli_mem.sv
design/tli_muldiv.sv
design/table_linear_interpolator.sv
dv/table_linear_interpolator_checker.sv
dv/table_linear_interpolator_tb.sv
